// File: hdl/kpi_pkg.sv
// Package holding the shared constants, types and helper function of the keyword page indexer.
package kpi_pkg;

    localparam int MAX_TERMS_DEF = 16;
    localparam int TERM_CHARS_DEF = 8;
    localparam int MAX_PAGES_DEF = 16;
    localparam int PAGE_BITS_DEF = 16;

    typedef enum logic [2:0] {
        OP_ADD   = 3'd0,
        OP_BEGIN = 3'd1,
        OP_TEXT  = 3'd2,
        OP_END   = 3'd3,
        OP_READ  = 3'd4
    } op_t;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_PRESENT = 3'd1,
        ST_FULL    = 3'd2,
        ST_LISTFUL = 3'd3,
        ST_BAD     = 3'd4
    } status_t;

    function automatic logic [7:0] lower_byte(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= 8'h41 && c <= 8'h5A)
        begin
            r = c + 8'h20;
        end
        return r;
    endfunction

endpackage

// File: hdl/kpi_page_ram.sv
// Page list memory with one write port and one registered read port.
module kpi_page_ram #(
    parameter int AW = 8,
    parameter int DW = 16
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [2**AW];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: hdl/keyword_page_indexer.sv
// Top level of the keyword page indexer.
// Commands are taken on start while busy is low; each command gives one
// result word, marked by done for exactly one cycle, which the receiver
// cannot stall. Text bytes and begin page go from idle straight to the
// response state; terms are matched in parallel against a window of
// recent bytes. Read entry passes through a wait state for the
// registered page memory read. When a new term lands at a sorted position
// below the last, add term moves each displaced page list one entry at a
// time through the page memory. End page walks every flagged term's list
// slot by slot through the page memory, shifting entries up to insert the
// page in order. Reset clears the term count, page counts, flags, window
// and page number; the page memory holds no reset and is only read where
// written.
module keyword_page_indexer #(
    parameter int MAX_TERMS = kpi_pkg::MAX_TERMS_DEF,
    parameter int TERM_CHARS = kpi_pkg::TERM_CHARS_DEF,
    parameter int MAX_PAGES_PER_TERM = kpi_pkg::MAX_PAGES_DEF,
    parameter int PAGE_BITS = kpi_pkg::PAGE_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  op,
    input  logic [63:0] term_chars,
    input  logic        term_too_long,
    input  logic [15:0] page_number,
    input  logic [7:0]  text_byte,
    input  logic [3:0]  entry_index,
    input  logic [3:0]  page_slot,
    output logic        done,
    output logic [2:0]  status,
    output logic [63:0] term_out,
    output logic [4:0]  term_total,
    output logic [4:0]  page_total,
    output logic [15:0] page_out
);

    localparam int TW = $clog2(MAX_TERMS);
    localparam int CW = $clog2(MAX_TERMS + 1);
    localparam int SW = (MAX_PAGES_PER_TERM > 1) ? $clog2(MAX_PAGES_PER_TERM) : 1;
    localparam int NW = $clog2(MAX_PAGES_PER_TERM + 1);
    localparam int AW = TW + SW;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_ADD   = 10'b0000000010,
        S_MVRD  = 10'b0000000100,
        S_MVWR  = 10'b0000001000,
        S_INS   = 10'b0000010000,
        S_EPNXT = 10'b0000100000,
        S_EPRD  = 10'b0001000000,
        S_EPCHK = 10'b0010000000,
        S_RDWT  = 10'b0100000000,
        S_RESP  = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;

    logic [63:0] store_reg [MAX_TERMS];
    logic [3:0]  len_reg [MAX_TERMS];
    logic [NW-1:0] cnt_reg [MAX_TERMS];
    logic [CW-1:0] count_reg;
    logic [MAX_TERMS-1:0] flags_reg;
    logic [63:0] window_reg;
    logic [PAGE_BITS-1:0] page_reg;

    logic [2:0]  st_reg;
    logic [63:0] tout_reg;
    logic [4:0]  ptot_reg;
    logic [15:0] pout_reg;
    logic        done_reg;

    logic [63:0] w_reg;
    logic [3:0]  wlen_reg;
    logic [TW-1:0] pos_reg;
    logic [TW-1:0] ti_reg;
    logic [SW-1:0] si_reg;
    logic [NW-1:0] n_reg;
    logic [PAGE_BITS-1:0] carry_reg;
    logic        ins_reg;
    logic [3:0]  rslot_reg;

    logic we;
    logic [AW-1:0] waddr, raddr;
    logic [15:0] wdata, rdata;

    kpi_page_ram #(.AW(AW), .DW(16)) u_ram (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    logic [63:0] norm;
    logic [3:0]  nlen;
    logic        stop;
    logic        dup;
    logic [TW-1:0] ins_pos;
    logic        found;
    logic [63:0] win_new;
    logic [MAX_TERMS-1:0] hit;
    logic [63:0] mask;

    always_comb
    begin
        norm = '0;
        nlen = '0;
        stop = 1'b0;
        for (int i = 0; i < 8; i++)
        begin
            if (!stop && term_chars[63-8*i -: 8] != 8'd0)
            begin
                norm[63-8*i -: 8] = kpi_pkg::lower_byte(term_chars[63-8*i -: 8]);
                nlen = nlen + 4'd1;
            end
            else
            begin
                stop = 1'b1;
            end
        end
        dup = 1'b0;
        found = 1'b0;
        ins_pos = count_reg[TW-1:0];
        for (int i = 0; i < MAX_TERMS; i++)
        begin
            if (i < count_reg)
            begin
                if (store_reg[i] == norm)
                begin
                    dup = 1'b1;
                end
                if (!found && norm < store_reg[i])
                begin
                    found = 1'b1;
                    ins_pos = TW'(i);
                end
            end
        end
        win_new = {window_reg[55:0], kpi_pkg::lower_byte(text_byte)};
        hit = '0;
        for (int i = 0; i < MAX_TERMS; i++)
        begin
            mask = '0;
            for (int k = 0; k < 8; k++)
            begin
                if (k < len_reg[i])
                begin
                    mask[8*k +: 8] = 8'hFF;
                end
            end
            if (i < count_reg && len_reg[i] != 4'd0 &&
                (win_new & mask) == ((store_reg[i] >> (64 - 8*len_reg[i])) & mask))
            begin
                hit[i] = 1'b1;
            end
        end
    end

    logic [TW-1:0] nxt_flag;
    logic          any_flag;

    always_comb
    begin
        any_flag = 1'b0;
        nxt_flag = '0;
        for (int i = MAX_TERMS - 1; i >= 0; i--)
        begin
            if (flags_reg[i] && i < count_reg)
            begin
                any_flag = 1'b1;
                nxt_flag = TW'(i);
            end
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;
    assign status = st_reg;
    assign term_out = tout_reg;
    assign term_total = 5'(count_reg);
    assign page_total = ptot_reg;
    assign page_out = pout_reg;

    always_comb
    begin
        state_next = state_reg;
        we = 1'b0;
        waddr = {ti_reg, si_reg};
        wdata = 16'(carry_reg);
        raddr = {ti_reg, si_reg};
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    unique case (op)
                        kpi_pkg::OP_ADD:   state_next = S_ADD;
                        kpi_pkg::OP_END:   state_next = S_EPNXT;
                        kpi_pkg::OP_READ:
                        begin
                            raddr = {entry_index[TW-1:0], page_slot[SW-1:0]};
                            state_next = S_RDWT;
                        end
                        default:           state_next = S_RESP;
                    endcase
                end
            end
            S_ADD:
            begin
                if (st_reg != kpi_pkg::ST_OK)
                begin
                    state_next = S_RESP;
                end
                else if (TW'(count_reg) == pos_reg)
                begin
                    state_next = S_INS;
                end
                else
                begin
                    state_next = S_MVRD;
                end
            end
            S_MVRD:
            begin
                raddr = {ti_reg - TW'(1), si_reg};
                state_next = S_MVWR;
            end
            S_MVWR:
            begin
                we = 1'b1;
                wdata = rdata;
                if (32'(si_reg) == MAX_PAGES_PER_TERM - 1 && ti_reg - TW'(1) == pos_reg)
                begin
                    state_next = S_INS;
                end
                else
                begin
                    state_next = S_MVRD;
                end
            end
            S_INS:   state_next = S_RESP;
            S_EPNXT:
            begin
                if (!any_flag)
                begin
                    state_next = S_RESP;
                end
                else if (cnt_reg[nxt_flag] == '0)
                begin
                    state_next = S_EPCHK;
                end
                else
                begin
                    state_next = S_EPRD;
                end
            end
            S_EPRD:  state_next = S_EPCHK;
            S_EPCHK:
            begin
                we = ins_reg;
                if (ins_reg)
                begin
                    if (32'(si_reg) + 1 > 32'(n_reg))
                    begin
                        state_next = S_EPNXT;
                    end
                    else if (32'(si_reg) + 1 == 32'(n_reg))
                    begin
                        state_next = S_EPCHK;
                    end
                    else
                    begin
                        state_next = S_EPRD;
                    end
                end
                else if (PAGE_BITS'(rdata) == page_reg)
                begin
                    state_next = S_EPNXT;
                end
                else if (page_reg < PAGE_BITS'(rdata) || 32'(si_reg) + 1 == 32'(n_reg))
                begin
                    state_next = (32'(n_reg) >= MAX_PAGES_PER_TERM) ? S_EPNXT : S_EPCHK;
                end
                else
                begin
                    state_next = S_EPRD;
                end
            end
            S_RDWT:  state_next = S_RESP;
            S_RESP:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            flags_reg <= '0;
            window_reg <= '0;
            page_reg <= '0;
            done_reg <= 1'b0;
            for (int i = 0; i < MAX_TERMS; i++)
            begin
                cnt_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            done_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        st_reg <= kpi_pkg::ST_OK;
                        tout_reg <= '0;
                        ptot_reg <= '0;
                        pout_reg <= '0;
                        rslot_reg <= page_slot;
                        ti_reg <= entry_index[TW-1:0];
                        unique case (op)
                            kpi_pkg::OP_ADD:
                            begin
                                w_reg <= norm;
                                wlen_reg <= nlen;
                                pos_reg <= ins_pos;
                                if (term_too_long || 32'(nlen) > TERM_CHARS)
                                begin
                                    st_reg <= kpi_pkg::ST_BAD;
                                end
                                else
                                begin
                                    tout_reg <= norm;
                                    if (dup)
                                    begin
                                        st_reg <= kpi_pkg::ST_PRESENT;
                                    end
                                    else if (32'(count_reg) >= MAX_TERMS)
                                    begin
                                        st_reg <= kpi_pkg::ST_FULL;
                                    end
                                end
                            end
                            kpi_pkg::OP_BEGIN:
                            begin
                                page_reg <= PAGE_BITS'(page_number);
                                flags_reg <= '0;
                                window_reg <= '0;
                            end
                            kpi_pkg::OP_TEXT:
                            begin
                                window_reg <= win_new;
                                flags_reg <= flags_reg | hit;
                            end
                            kpi_pkg::OP_END: ;
                            kpi_pkg::OP_READ:
                            begin
                                if (5'(entry_index) >= 5'(count_reg) ||
                                    32'(entry_index) >= MAX_TERMS)
                                begin
                                    st_reg <= kpi_pkg::ST_BAD;
                                end
                            end
                            default: st_reg <= kpi_pkg::ST_BAD;
                        endcase
                    end
                end
                S_ADD:
                begin
                    if (st_reg == kpi_pkg::ST_OK)
                    begin
                        ti_reg <= TW'(count_reg);
                        si_reg <= '0;
                    end
                end
                S_MVRD: ;
                S_MVWR:
                begin
                    if (32'(si_reg) == MAX_PAGES_PER_TERM - 1)
                    begin
                        si_reg <= '0;
                        ti_reg <= ti_reg - TW'(1);
                    end
                    else
                    begin
                        si_reg <= si_reg + SW'(1);
                    end
                end
                S_INS:
                begin
                    for (int i = MAX_TERMS - 1; i > 0; i--)
                    begin
                        if (TW'(i) > pos_reg && i < 32'(count_reg) + 1)
                        begin
                            store_reg[i] <= store_reg[i-1];
                            len_reg[i] <= len_reg[i-1];
                            cnt_reg[i] <= cnt_reg[i-1];
                            flags_reg[i] <= flags_reg[i-1];
                        end
                    end
                    store_reg[pos_reg] <= w_reg;
                    len_reg[pos_reg] <= wlen_reg;
                    cnt_reg[pos_reg] <= '0;
                    flags_reg[pos_reg] <= 1'b0;
                    count_reg <= count_reg + CW'(1);
                end
                S_EPNXT:
                begin
                    if (!any_flag)
                    begin
                        flags_reg <= '0;
                        window_reg <= '0;
                    end
                    else
                    begin
                        ti_reg <= nxt_flag;
                        flags_reg[nxt_flag] <= 1'b0;
                        si_reg <= '0;
                        n_reg <= cnt_reg[nxt_flag];
                        ins_reg <= 1'b0;
                        carry_reg <= page_reg;
                        if (cnt_reg[nxt_flag] == '0)
                        begin
                            ins_reg <= 1'b1;
                        end
                    end
                end
                S_EPRD: ;
                S_EPCHK:
                begin
                    if (ins_reg)
                    begin
                        if (32'(si_reg) + 1 > 32'(n_reg))
                        begin
                            cnt_reg[ti_reg] <= n_reg + NW'(1);
                        end
                        else
                        begin
                            carry_reg <= PAGE_BITS'(rdata);
                            si_reg <= si_reg + SW'(1);
                        end
                    end
                    else if (PAGE_BITS'(rdata) == page_reg)
                    begin
                        // An already listed page is left alone.
                    end
                    else if (page_reg < PAGE_BITS'(rdata))
                    begin
                        if (32'(n_reg) >= MAX_PAGES_PER_TERM)
                        begin
                            st_reg <= kpi_pkg::ST_LISTFUL;
                        end
                        else
                        begin
                            ins_reg <= 1'b1;
                            carry_reg <= page_reg;
                        end
                    end
                    else if (32'(si_reg) + 1 == 32'(n_reg))
                    begin
                        if (32'(n_reg) >= MAX_PAGES_PER_TERM)
                        begin
                            st_reg <= kpi_pkg::ST_LISTFUL;
                        end
                        else
                        begin
                            ins_reg <= 1'b1;
                            si_reg <= si_reg + SW'(1);
                        end
                    end
                    else
                    begin
                        si_reg <= si_reg + SW'(1);
                    end
                end
                S_RDWT:
                begin
                    if (st_reg == kpi_pkg::ST_OK)
                    begin
                        tout_reg <= store_reg[ti_reg];
                        ptot_reg <= 5'(cnt_reg[ti_reg]);
                        if (5'(rslot_reg) < 5'(cnt_reg[ti_reg]))
                        begin
                            pout_reg <= rdata;
                        end
                        else
                        begin
                            st_reg <= kpi_pkg::ST_BAD;
                        end
                    end
                end
                S_RESP:  done_reg <= 1'b1;
                default: ;
            endcase
        end
    end

endmodule

// File: dv/keyword_page_indexer_checker.sv
// Checker for the keyword page indexer: predicts every result word and compares it.
module keyword_page_indexer_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [2:0]  op,
    input  logic [63:0] term_chars,
    input  logic        term_too_long,
    input  logic [15:0] page_number,
    input  logic [7:0]  text_byte,
    input  logic [3:0]  entry_index,
    input  logic [3:0]  page_slot,
    input  logic        done,
    input  logic [2:0]  status,
    input  logic [63:0] term_out,
    input  logic [4:0]  term_total,
    input  logic [4:0]  page_total,
    input  logic [15:0] page_out,
    output int          fail_count,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NT = kpi_pkg::MAX_TERMS_DEF;
    localparam int NP = kpi_pkg::MAX_PAGES_DEF;

    typedef struct packed {
        logic [2:0]  st;
        logic [63:0] term;
        logic [4:0]  terms;
        logic [4:0]  pages;
        logic [15:0] page;
    } word_t;

    logic [63:0] terms_held [NT];
    int          term_len [NT];
    int          n_terms;
    logic [15:0] pages_of [NT][NP];
    int          n_pages [NT];
    logic [NT-1:0] hit;
    logic [63:0] window;
    logic [15:0] page_now;
    word_t       expected_words [$];

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
    endfunction

    task automatic predict(input logic [2:0] o, input logic [63:0] raw, input logic tl,
        input logic [15:0] pn, input logic [7:0] tb, input logic [3:0] ei,
        input logic [3:0] ps);
        word_t w;
        logic [63:0] nt;
        logic [63:0] m;
        int len;
        int pos;
        int n;
        bit dup;
        w = '0;
        case (o)
            kpi_pkg::OP_ADD:
            begin
                nt = '0;
                len = 0;
                while (len < 8 && raw[63-8*len -: 8] != 8'h00)
                begin
                    nt[63-8*len -: 8] = to_lower(raw[63-8*len -: 8]);
                    len++;
                end
                if (tl)
                begin
                    w.st = kpi_pkg::ST_BAD;
                end
                else
                begin
                    w.term = nt;
                    dup = 0;
                    for (int i = 0; i < n_terms; i++)
                        if (terms_held[i] == nt)
                            dup = 1;
                    if (dup)
                        w.st = kpi_pkg::ST_PRESENT;
                    else if (n_terms >= NT)
                        w.st = kpi_pkg::ST_FULL;
                    else
                    begin
                        pos = n_terms;
                        for (int i = n_terms - 1; i >= 0; i--)
                            if (nt < terms_held[i])
                                pos = i;
                        for (int i = n_terms; i > pos; i--)
                        begin
                            terms_held[i] = terms_held[i-1];
                            term_len[i] = term_len[i-1];
                            n_pages[i] = n_pages[i-1];
                            pages_of[i] = pages_of[i-1];
                            hit[i] = hit[i-1];
                        end
                        terms_held[pos] = nt;
                        term_len[pos] = len;
                        n_pages[pos] = 0;
                        hit[pos] = 1'b0;
                        n_terms++;
                        w.st = kpi_pkg::ST_OK;
                    end
                end
            end
            kpi_pkg::OP_BEGIN:
            begin
                page_now = pn;
                hit = '0;
                window = '0;
            end
            kpi_pkg::OP_TEXT:
            begin
                window = {window[55:0], to_lower(tb)};
                for (int i = 0; i < n_terms; i++)
                begin
                    if (term_len[i] == 0)
                        continue;
                    m = (term_len[i] == 8) ? '1 : ((64'd1 << (8 * term_len[i])) - 64'd1);
                    if ((window & m) == (terms_held[i] >> (64 - 8 * term_len[i])))
                        hit[i] = 1'b1;
                end
            end
            kpi_pkg::OP_END:
            begin
                for (int i = 0; i < n_terms; i++)
                begin
                    if (!hit[i])
                        continue;
                    n = n_pages[i];
                    dup = 0;
                    for (int j = 0; j < n; j++)
                        if (pages_of[i][j] == page_now)
                            dup = 1;
                    if (dup)
                        continue;
                    if (n >= NP)
                    begin
                        w.st = kpi_pkg::ST_LISTFUL;
                        continue;
                    end
                    pos = n;
                    for (int j = n - 1; j >= 0; j--)
                        if (page_now < pages_of[i][j])
                            pos = j;
                    for (int j = n; j > pos; j--)
                        pages_of[i][j] = pages_of[i][j-1];
                    pages_of[i][pos] = page_now;
                    n_pages[i] = n + 1;
                end
                hit = '0;
                window = '0;
            end
            kpi_pkg::OP_READ:
            begin
                if (ei >= n_terms)
                    w.st = kpi_pkg::ST_BAD;
                else
                begin
                    w.term = terms_held[ei];
                    w.pages = 5'(n_pages[ei]);
                    if (ps < n_pages[ei])
                        w.page = pages_of[ei][ps];
                    else
                        w.st = kpi_pkg::ST_BAD;
                end
            end
            default:
                w.st = kpi_pkg::ST_BAD;
        endcase
        w.terms = 5'(n_terms);
        expected_words.push_back(w);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        word_t e;
        if (!rst_n)
        begin
            n_terms = 0;
            hit = '0;
            window = '0;
            page_now = '0;
            for (int i = 0; i < NT; i++)
                n_pages[i] = 0;
            expected_words.delete();
            fail_count = 0;
        end
        else
        begin
            if (done)
            begin
                if (expected_words.size() == 0)
                begin
                    $error("result word with nothing expected");
                    fail_count++;
                end
                else
                begin
                    e = expected_words.pop_front();
                    if (status !== e.st)
                    begin
                        $error("status: expected %0d, got %0d", e.st, status);
                        fail_count++;
                    end
                    if (term_out !== e.term)
                    begin
                        $error("term_out: expected %h, got %h", e.term, term_out);
                        fail_count++;
                    end
                    if (term_total !== e.terms)
                    begin
                        $error("term_total: expected %0d, got %0d", e.terms, term_total);
                        fail_count++;
                    end
                    if (page_total !== e.pages)
                    begin
                        $error("page_total: expected %0d, got %0d", e.pages, page_total);
                        fail_count++;
                    end
                    if (page_out !== e.page)
                    begin
                        $error("page_out: expected %0d, got %0d", e.page, page_out);
                        fail_count++;
                    end
                end
            end
            if (start && !busy)
                predict(op, term_chars, term_too_long, page_number, text_byte,
                    entry_index, page_slot);
        end
        pending = expected_words.size();
    end
endmodule

// File: dv/keyword_page_indexer_test.sv
// Testbench top: drives command words into the keyword page indexer and gives the verdict.
module keyword_page_indexer_test;
    timeunit 1ns;
    timeprecision 1ps;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        start = 0;
    logic        busy;
    logic [2:0]  op = '0;
    logic [63:0] term_chars = '0;
    logic        term_too_long = 0;
    logic [15:0] page_number = '0;
    logic [7:0]  text_byte = '0;
    logic [3:0]  entry_index = '0;
    logic [3:0]  page_slot = '0;
    logic        done;
    logic [2:0]  status;
    logic [63:0] term_out;
    logic [4:0]  term_total;
    logic [4:0]  page_total;
    logic [15:0] page_out;
    int          fail_count;
    int          pending;
    int          cycles = 0;
    int          gap_pct = 22;
    logic [63:0] vocab [8];

    always #5 clk = ~clk;

    keyword_page_indexer dut (.*);
    keyword_page_indexer_checker checker_i (.*);

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > 3000000)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic send(input logic [2:0] o, input logic [63:0] t = '0,
        input logic tl = 0, input logic [15:0] pn = '0, input logic [7:0] tb = '0,
        input logic [3:0] ei = '0, input logic [3:0] ps = '0);
        while ($urandom_range(99) < gap_pct)
        begin
            start <= 0;
            @(posedge clk);
        end
        op <= o;
        term_chars <= t;
        term_too_long <= tl;
        page_number <= pn;
        text_byte <= tb;
        entry_index <= ei;
        page_slot <= ps;
        start <= 1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    function automatic logic [63:0] rand_term();
        logic [63:0] t;
        int len;
        t = '0;
        len = $urandom_range(1, 3);
        for (int i = 0; i < len; i++)
            t[63-8*i -: 8] = ($urandom_range(1) ? 8'h41 : 8'h61) + 8'($urandom_range(3));
        return t;
    endfunction

    task automatic page_of_text(input int n);
        logic [63:0] w;
        send(kpi_pkg::OP_BEGIN, '0, 0,
            $urandom_range(1) ? 16'($urandom_range(20)) : 16'($urandom));
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(5) == 0)
                send(kpi_pkg::OP_TEXT, '0, 0, '0, 8'($urandom));
            else
            begin
                w = vocab[$urandom_range(7)];
                send(kpi_pkg::OP_TEXT, '0, 0, '0, w[63:56]);
            end
        end
        send(kpi_pkg::OP_END);
    endtask

    task automatic random_phase(input int n);
        int k;
        for (int i = 0; i < n; i++)
        begin
            k = $urandom_range(99);
            if (k < 8)
                send(kpi_pkg::OP_ADD,
                    $urandom_range(3) == 0 ? {$urandom, $urandom} : rand_term(),
                    $urandom_range(9) == 0);
            else if (k < 60)
                send(kpi_pkg::OP_TEXT, '0, 0, '0,
                    $urandom_range(1) ? 8'h61 + 8'($urandom_range(3)) : 8'($urandom));
            else if (k < 66)
                send(kpi_pkg::OP_BEGIN, '0, 0,
                    $urandom_range(1) ? 16'($urandom_range(20)) : 16'($urandom));
            else if (k < 72)
                send(kpi_pkg::OP_END);
            else if (k < 76)
                send(3'($urandom_range(5, 7)));
            else
                send(kpi_pkg::OP_READ, 64'($urandom), 0, '0, '0, 4'($urandom),
                    4'($urandom));
        end
    endtask

    initial
    begin
        for (int i = 0; i < 8; i++)
            vocab[i] = {8'h61 + i[7:0], 56'h0};
        repeat (3) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        send(kpi_pkg::OP_READ);
        send(kpi_pkg::OP_ADD, 64'h4142_4344_4546_4748);
        send(kpi_pkg::OP_ADD, 64'h6162_6364_6566_6768);
        send(kpi_pkg::OP_ADD, '0);
        send(kpi_pkg::OP_ADD, 64'h4100_FFFF_FFFF_FFFF);
        send(kpi_pkg::OP_ADD, 64'h6263_0000_0000_0000, 1);
        send(kpi_pkg::OP_ADD, 64'hFFFF_FFFF_FFFF_FFFF);
        send(kpi_pkg::OP_BEGIN, '0, 0, 16'hFFFF);
        send(kpi_pkg::OP_TEXT, '0, 0, '0, 8'h41);
        send(kpi_pkg::OP_TEXT, '0, 0, '0, 8'h00);
        send(kpi_pkg::OP_TEXT, '0, 0, '0, 8'hFF);
        send(kpi_pkg::OP_END);
        send(kpi_pkg::OP_BEGIN, '0, 0, 16'h0000);
        send(kpi_pkg::OP_TEXT, '0, 0, '0, 8'h61);
        send(kpi_pkg::OP_END);
        send(kpi_pkg::OP_END);
        send(kpi_pkg::OP_READ, '0, 0, '0, '0, 4'd1, 4'd0);
        send(kpi_pkg::OP_READ, '0, 0, '0, '0, 4'd1, 4'd1);
        send(kpi_pkg::OP_READ, '0, 0, '0, '0, 4'd1, 4'd15);
        send(kpi_pkg::OP_READ, '0, 0, '0, '0, 4'd15, 4'd0);
        send(3'd7);
        for (int i = 0; i < 14; i++)
            send(kpi_pkg::OP_ADD, {8'h61 + i[7:0], 8'h61 + i[7:0], 48'h0});
        send(kpi_pkg::OP_ADD, 64'h7A00_0000_0000_0000);
        for (int p = 0; p < 18; p++)
        begin
            send(kpi_pkg::OP_BEGIN, '0, 0, 16'(p * 7 % 19));
            send(kpi_pkg::OP_TEXT, '0, 0, '0, 8'h41);
            send(kpi_pkg::OP_END);
        end
        for (int s = 0; s < 16; s++)
            send(kpi_pkg::OP_READ, '0, 0, '0, '0, 4'd1, s[3:0]);
        for (int ph = 0; ph < 3; ph++)
        begin
            gap_pct = (ph == 0) ? 22 : (ph == 1) ? 75 : 0;
            for (int r = 0; r < 6; r++)
                page_of_text($urandom_range(2, 10));
            random_phase(450);
        end
        start <= 0;
        while (pending != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
